// File: sv/imgconv_pkg.sv
package imgconv_pkg;

   localparam int COORD_W    = 7;
   localparam int CHAN_W     = 16;
   localparam int COEF_W     = 16;
   localparam int CIDX_W     = 6;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int RAD_W      = 2;
   localparam int FRAC_BITS  = 14;
   localparam int PROD_W     = CHAN_W + 1 + COEF_W;
   localparam int ACC_W      = 38;
   localparam int NUM_CHAN   = 4;

   localparam int DEF_MAX_WIDTH  = 128;
   localparam int DEF_MAX_HEIGHT = 128;
   localparam int DEF_MAX_KERNEL = 7;

   localparam logic [CMD_W-1:0] CMD_LOAD_PIXEL = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_COEF  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_RADIUS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_MODE     = 2'd3;

   localparam logic [CSR_DATA_W-1:0] RST_IMAGE_WIDTH   = 8'd128;
   localparam logic [CSR_DATA_W-1:0] RST_IMAGE_HEIGHT  = 8'd128;
   localparam logic [RAD_W-1:0]      RST_KERNEL_RADIUS = 2'd1;
   localparam logic                  RST_EDGE_MODE     = 1'b0;

   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(8192);

endpackage

// File: sv/image_convolution_2d_top.sv
// channel   ports                         direction  transaction
// req       req_valid/req_stall + fields  in         load pixel, load coefficient, compute
// rsp       rsp_valid/rsp_stall + fields  out        one filtered pixel per compute
// csr       csr_wr_en/csr_index/csr_data  in         register write, no read-back
//
// loads may follow back to back
// a compute is paced by the single frame store read port: one kernel tap is read
// and multiplied per cycle; seven remainder steps, one per bit, first reduce the
// center column and row modulo the image size
// reset restores the registers only; both stores hold nothing until written
// a result waiting under rsp_stall holds the block only at the end of the next compute
module image_convolution_2d_top #(
   parameter int MAX_WIDTH  = imgconv_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = imgconv_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_KERNEL = imgconv_pkg::DEF_MAX_KERNEL
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [imgconv_pkg::CMD_W-1:0]         req_command,
   input  logic [imgconv_pkg::COORD_W-1:0]       req_pos_x,
   input  logic [imgconv_pkg::COORD_W-1:0]       req_pos_y,
   input  logic [imgconv_pkg::CIDX_W-1:0]        req_coef_index,
   input  logic signed [imgconv_pkg::COEF_W-1:0] req_coef_value,
   input  logic [imgconv_pkg::CHAN_W-1:0]        req_in_red,
   input  logic [imgconv_pkg::CHAN_W-1:0]        req_in_green,
   input  logic [imgconv_pkg::CHAN_W-1:0]        req_in_blue,
   input  logic [imgconv_pkg::CHAN_W-1:0]        req_in_alpha,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [imgconv_pkg::COORD_W-1:0]       rsp_out_x,
   output logic [imgconv_pkg::COORD_W-1:0]       rsp_out_y,
   output logic [imgconv_pkg::CHAN_W-1:0]        rsp_out_red,
   output logic [imgconv_pkg::CHAN_W-1:0]        rsp_out_green,
   output logic [imgconv_pkg::CHAN_W-1:0]        rsp_out_blue,
   output logic [imgconv_pkg::CHAN_W-1:0]        rsp_out_alpha,
   input  logic                                  csr_wr_en,
   input  logic [imgconv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [imgconv_pkg::CSR_DATA_W-1:0]    csr_data
);
   import imgconv_pkg::*;

   localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NCOEF    = MAX_KERNEL * MAX_KERNEL;
   localparam int KADDR_W  = (NCOEF > 1) ? $clog2(NCOEF) : 1;
   localparam int R_MAX    = (MAX_KERNEL - 1) / 2;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_REM  = 3'd1;
   localparam logic [2:0] ST_BACK = 3'd2;
   localparam logic [2:0] ST_RUN  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [CSR_DATA_W-1:0] width_ff;
   logic [CSR_DATA_W-1:0] height_ff;
   logic [RAD_W-1:0]      radius_ff;
   logic                  edge_ff;

   logic [CSR_DATA_W-1:0] w_eff;
   logic [CSR_DATA_W-1:0] h_eff;
   logic [RAD_W-1:0]      r_eff;
   logic [2:0]            side_m1;

   logic [2:0]            state_ff, state_in;
   logic [2:0]            bit_ff, bit_in;
   logic [RAD_W-1:0]      back_ff, back_in;
   logic [2:0]            i_ff, i_in;
   logic [2:0]            j_ff, j_in;
   logic [CIDX_W-1:0]     tap_ff, tap_in;
   logic [COORD_W-1:0]    px_ff, px_in;
   logic [COORD_W-1:0]    py_ff, py_in;
   logic [7:0]            wx_ff, wx_in;
   logic [7:0]            wx0_ff, wx0_in;
   logic [7:0]            wy_ff, wy_in;
   logic signed [8:0]     rawx_ff, rawx_in;
   logic signed [8:0]     rawx0_ff, rawx0_in;
   logic signed [8:0]     rawy_ff, rawy_in;

   logic [8:0]            remx_t;
   logic [8:0]            remy_t;
   logic [7:0]            sx;
   logic [7:0]            sy;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     wr_addr;

   logic                  req_acc;
   logic                  pix_we;
   logic                  coef_we;
   logic                  issue;
   logic                  out_free;
   logic                  out_load;

   logic [NUM_CHAN*CHAN_W-1:0]     frame_mem [DEPTH];
   logic signed [COEF_W-1:0]       coef_mem [NCOEF];
   logic [NUM_CHAN*CHAN_W-1:0]     pix_rd_ff;
   logic signed [COEF_W-1:0]       coef_rd_ff;
   logic                           rd_vld_ff;
   logic                           mul_vld_ff;
   logic signed [PROD_W-1:0]       prod_ff [NUM_CHAN];
   logic signed [ACC_W-1:0]        acc_ff [NUM_CHAN];

   logic                           rsp_valid_ff;
   logic [COORD_W-1:0]             out_x_ff;
   logic [COORD_W-1:0]             out_y_ff;
   logic [CHAN_W-1:0]              out_ch_ff [NUM_CHAN];

   function automatic logic [7:0] clamp_coord(input logic signed [8:0] v,
                                              input logic [7:0] size);
      logic [7:0] res;
      if (v < 9'sd0) begin
         res = 8'd0;
      end else if (v >= $signed({1'b0, size})) begin
         res = size - 8'd1;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

   function automatic logic [7:0] wrap_inc(input logic [7:0] v, input logic [7:0] size);
      return (v == size - 8'd1) ? 8'd0 : v + 8'd1;
   endfunction

   function automatic logic [7:0] wrap_dec(input logic [7:0] v, input logic [7:0] size);
      return (v == 8'd0) ? size - 8'd1 : v - 8'd1;
   endfunction

   function automatic logic [7:0] rem_step(input logic [8:0] t, input logic [7:0] size);
      logic [8:0] d;
      d = t - {1'b0, size};
      return (t >= {1'b0, size}) ? d[7:0] : t[7:0];
   endfunction

   function automatic logic [CHAN_W-1:0] round_sat(input logic signed [ACC_W-1:0] s);
      logic [ACC_W-1:0] t;
      logic [CHAN_W-1:0] res;
      t = s + ROUND_HALF;
      if (s <= 0) begin
         res = '0;
      end else if (|t[ACC_W-1:FRAC_BITS+CHAN_W]) begin
         res = '1;
      end else begin
         res = t[FRAC_BITS+CHAN_W-1:FRAC_BITS];
      end
      return res;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
         radius_ff <= RST_KERNEL_RADIUS;
         edge_ff   <= RST_EDGE_MODE;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT:  height_ff <= csr_data;
            CSR_KERNEL_RADIUS: radius_ff <= csr_data[RAD_W-1:0];
            CSR_EDGE_MODE:     edge_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_eff = 8'd1;
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = 8'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = 8'd1;
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = 8'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      if (32'(radius_ff) * 2 + 1 > MAX_KERNEL) begin
         r_eff = RAD_W'(R_MAX);
      end else begin
         r_eff = radius_ff;
      end
   end

   assign side_m1   = {r_eff, 1'b0};
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign pix_we    = req_acc && (req_command == CMD_LOAD_PIXEL) &&
                      (32'(req_pos_x) < MAX_WIDTH) && (32'(req_pos_y) < MAX_HEIGHT);
   assign coef_we   = req_acc && (req_command == CMD_LOAD_COEF) &&
                      (32'(req_coef_index) < NCOEF);
   assign issue     = (state_ff == ST_RUN);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = (state_ff == ST_FIN) && !rd_vld_ff && !mul_vld_ff && out_free;

   assign remx_t  = {wx_ff, px_ff[bit_ff]};
   assign remy_t  = {wy_ff, py_ff[bit_ff]};
   assign sx      = edge_ff ? wx_ff : clamp_coord(rawx_ff, w_eff);
   assign sy      = edge_ff ? wy_ff : clamp_coord(rawy_ff, h_eff);
   assign rd_addr = ADDR_W'(ADDR_W'(sy) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sx));
   assign wr_addr = ADDR_W'(ADDR_W'(req_pos_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(req_pos_x));

   // sequencer
   always_comb begin
      state_in = state_ff;
      bit_in   = bit_ff;
      back_in  = back_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      tap_in   = tap_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      wx_in    = wx_ff;
      wx0_in   = wx0_ff;
      wy_in    = wy_ff;
      rawx_in  = rawx_ff;
      rawx0_in = rawx0_ff;
      rawy_in  = rawy_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_command == CMD_COMPUTE) begin
               state_in = ST_REM;
               bit_in   = 3'd6;
               i_in     = 3'd0;
               j_in     = 3'd0;
               tap_in   = '0;
               px_in    = req_pos_x;
               py_in    = req_pos_y;
               wx_in    = 8'd0;
               wx0_in   = 8'd0;
               wy_in    = 8'd0;
               rawx0_in = $signed({2'b00, req_pos_x}) - $signed({7'd0, r_eff});
               rawx_in  = $signed({2'b00, req_pos_x}) - $signed({7'd0, r_eff});
               rawy_in  = $signed({2'b00, req_pos_y}) - $signed({7'd0, r_eff});
            end
         end
         ST_REM: begin
            // one remainder bit per cycle for column and row
            wx_in  = rem_step(remx_t, w_eff);
            wx0_in = rem_step(remx_t, w_eff);
            wy_in  = rem_step(remy_t, h_eff);
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) begin
               back_in  = r_eff;
               state_in = (r_eff == '0) ? ST_RUN : ST_BACK;
            end
         end
         ST_BACK: begin
            wx_in   = wrap_dec(wx_ff, w_eff);
            wx0_in  = wrap_dec(wx_ff, w_eff);
            wy_in   = wrap_dec(wy_ff, h_eff);
            back_in = back_ff - RAD_W'(1);
            if (back_ff == RAD_W'(1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            tap_in = tap_ff + CIDX_W'(1);
            if (i_ff == side_m1) begin
               i_in    = 3'd0;
               j_in    = j_ff + 3'd1;
               wx_in   = wx0_ff;
               rawx_in = rawx0_ff;
               wy_in   = wrap_inc(wy_ff, h_eff);
               rawy_in = rawy_ff + 9'sd1;
               if (j_ff == side_m1) begin
                  state_in = ST_FIN;
               end
            end else begin
               i_in    = i_ff + 3'd1;
               wx_in   = wrap_inc(wx_ff, w_eff);
               rawx_in = rawx_ff + 9'sd1;
            end
         end
         ST_FIN: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bit_ff   <= bit_in;
      back_ff  <= back_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      tap_ff   <= tap_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      wx_ff    <= wx_in;
      wx0_ff   <= wx0_in;
      wy_ff    <= wy_in;
      rawx_ff  <= rawx_in;
      rawx0_ff <= rawx0_in;
      rawy_ff  <= rawy_in;
   end

   // frame and coefficient stores
   always_ff @(posedge clock) begin
      if (pix_we) begin
         frame_mem[wr_addr] <= {req_in_alpha, req_in_blue, req_in_green, req_in_red};
      end
      if (issue) begin
         pix_rd_ff <= frame_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[KADDR_W'(req_coef_index)] <= req_coef_value;
      end
      if (issue) begin
         coef_rd_ff <= coef_mem[KADDR_W'(tap_ff)];
      end
   end

   // shared multiply-accumulate, four channel lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= issue;
         mul_vld_ff <= rd_vld_ff;
      end
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         prod_ff[ch] <= $signed({1'b0, pix_rd_ff[CHAN_W*ch +: CHAN_W]}) * coef_rd_ff;
         if (req_acc && req_command == CMD_COMPUTE) begin
            acc_ff[ch] <= '0;
         end else if (mul_vld_ff) begin
            acc_ff[ch] <= acc_ff[ch] + ACC_W'(prod_ff[ch]);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         out_x_ff <= px_ff;
         out_y_ff <= py_ff;
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            out_ch_ff[ch] <= round_sat(acc_ff[ch]);
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = out_x_ff;
   assign rsp_out_y     = out_y_ff;
   assign rsp_out_red   = out_ch_ff[0];
   assign rsp_out_green = out_ch_ff[1];
   assign rsp_out_blue  = out_ch_ff[2];
   assign rsp_out_alpha = out_ch_ff[3];

   a_pipe_empty_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!rd_vld_ff && !mul_vld_ff))
      else $error("mac pipe busy while idle");

   a_read_feeds_mul: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |=> mul_vld_ff)
      else $error("store read not followed by multiply");

   a_compute_starts: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_command == CMD_COMPUTE) |=> (state_ff == ST_REM))
      else $error("compute transaction did not start reduction");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised outside final step");

endmodule
